[sv/mkd_pkg.sv]
`default_nettype none

package mkd_pkg;

   localparam int TIME_WIDTH   = 32;
   localparam int PORT_WIDTH   = 8;
   localparam int SEL_WIDTH    = 3;
   localparam int IVAL_WIDTH   = 16;
   localparam int MAP_WIDTH    = 21;
   localparam int MASK_WIDTH   = 7;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 21;
   localparam int REQ_DATA_WIDTH = 48;
   localparam int RSP_DATA_WIDTH = 8;

   localparam logic [CSR_IDX_WIDTH-1:0] REG_POLL_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_SETTLE_TIME   = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_KEY_BIT_MAP   = 2'd2;

   localparam logic [IVAL_WIDTH-1:0] POLL_RESET   = 16'd15;
   localparam logic [IVAL_WIDTH-1:0] SETTLE_RESET = 16'd30;
   localparam logic [MAP_WIDTH-1:0]  MAP_RESET    = 21'd1746500;

   typedef struct packed {
      logic [MAP_WIDTH-1:0]  key_bit_map;
      logic [IVAL_WIDTH-1:0] settle_time;
      logic [IVAL_WIDTH-1:0] poll_interval;
   } config_type;

   typedef struct packed {
      logic stable;
      logic press;
   } lane_status_type;

   typedef struct packed {
      logic                  boot_event;
      logic [MASK_WIDTH-1:0] pressed_mask;
   } rsp_type;

endpackage

`default_nettype wire

[sv/mkd_key_lane.sv]
`default_nettype none

module mkd_key_lane (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  sample,
   input  wire                                  raw,
   input  wire  [mkd_pkg::TIME_WIDTH-1:0]       now_ms,
   input  wire  [mkd_pkg::IVAL_WIDTH-1:0]       settle_time,
   output mkd_pkg::lane_status_type             status
);

   logic                             last_raw_ff, last_raw_in;
   logic                             stable_ff, stable_in;
   logic [mkd_pkg::TIME_WIDTH-1:0]   change_time_ff, change_time_in;
   logic [mkd_pkg::TIME_WIDTH-1:0]   elapsed;
   logic                             settled;
   logic                             accept_level;

   assign elapsed = now_ms - change_time_ff;
   assign settled = elapsed >= {{(mkd_pkg::TIME_WIDTH-mkd_pkg::IVAL_WIDTH){1'b0}}, settle_time};

   always_comb begin
      last_raw_in    = last_raw_ff;
      stable_in      = stable_ff;
      change_time_in = change_time_ff;
      accept_level   = 1'b0;
      if (sample) begin
         if (raw != last_raw_ff) begin
            last_raw_in    = raw;
            change_time_in = now_ms;
         end else if (raw != stable_ff && settled) begin
            stable_in    = raw;
            accept_level = 1'b1;
         end
      end
   end

   assign status.stable = stable_in;
   assign status.press  = accept_level & raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff    <= 1'b0;
         stable_ff      <= 1'b0;
         change_time_ff <= '0;
      end else begin
         last_raw_ff    <= last_raw_in;
         stable_ff      <= stable_in;
         change_time_ff <= change_time_in;
      end
   end

endmodule

`default_nettype wire

[sv/mkd_merge.sv]
`default_nettype none

module mkd_merge #(
   parameter int KEY_COUNT = 7
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        beat,
   input  wire                        take,
   input  wire  [KEY_COUNT-1:0]       key_stable,
   input  wire                        boot_press,
   output mkd_pkg::rsp_type           result
);

   logic boot_pending_ff, boot_pending_in;
   logic pending_now;

   assign pending_now = boot_pending_ff | boot_press;

   always_comb begin
      boot_pending_in = boot_pending_ff;
      if (beat) begin
         boot_pending_in = pending_now & ~take;
      end
   end

   assign result.boot_event = take & pending_now;

   for (genvar j = 0; j < mkd_pkg::MASK_WIDTH; j++) begin : g_mask
      if (j < KEY_COUNT) begin : g_key
         assign result.pressed_mask[j] = key_stable[j];
      end else begin : g_pad
         assign result.pressed_mask[j] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         boot_pending_ff <= 1'b0;
      end else begin
         boot_pending_ff <= boot_pending_in;
      end
   end

endmodule

`default_nettype wire

[sv/mkd_skid.sv]
`default_nettype none

module mkd_skid (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_valid,
   output logic                     in_ready,
   input  wire mkd_pkg::rsp_type    in_data,
   output logic                     out_valid,
   input  wire                      out_ready,
   output mkd_pkg::rsp_type         out_data
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   mkd_pkg::rsp_type out_data_ff, out_data_in;
   mkd_pkg::rsp_type skid_data_ff, skid_data_in;

   assign in_ready  = ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_ready) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || out_ready) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

[sv/multi_key_debouncer.sv]
`default_nettype none

// timestamp debouncer for up to seven expander keys and one boot key. one
// beat is taken per clock and its result leaves the cycle after, unless
// stalled: every key has its own lane holding last raw level, stable level
// and change time, and all lanes and the boot lane update in a single cycle.
// a poll acts only when poll_interval ms (mod 2^32) have passed since the
// last one. a two-entry output buffer lets req_tready stay high while one
// result is stalled on rsp_tready. csr writes take effect on the next clock.
module multi_key_debouncer #(
   parameter int KEY_COUNT = 7
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // now_ms[31:0], port_bits[39:32], boot_level[40], take_boot_event[41]
   input  wire  [mkd_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // pressed_mask[6:0], boot_event[7]
   output logic [mkd_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   input  wire                                   csr_wr_en,
   input  wire  [mkd_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  wire  [mkd_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   mkd_pkg::config_type                 cfg_ff, cfg_in;
   logic [mkd_pkg::TIME_WIDTH-1:0]      last_poll_ff, last_poll_in;
   logic [mkd_pkg::TIME_WIDTH-1:0]      now_ms;
   logic [mkd_pkg::PORT_WIDTH-1:0]      port_bits;
   logic                                boot_level;
   logic                                take_boot_event;
   logic [mkd_pkg::TIME_WIDTH-1:0]      since_poll;
   logic                                poll_due;
   logic                                beat;
   logic                                sample;
   logic [KEY_COUNT-1:0]                key_stable;
   mkd_pkg::lane_status_type            boot_status;
   mkd_pkg::rsp_type                    result;
   mkd_pkg::rsp_type                    rsp_data;

   assign now_ms          = req_tdata[31:0];
   assign port_bits       = req_tdata[39:32];
   assign boot_level      = req_tdata[40];
   assign take_boot_event = req_tdata[41];

   assign beat       = req_tvalid & req_tready;
   assign since_poll = now_ms - last_poll_ff;
   assign poll_due   = since_poll >=
      {{(mkd_pkg::TIME_WIDTH-mkd_pkg::IVAL_WIDTH){1'b0}}, cfg_ff.poll_interval};
   assign sample     = beat & poll_due;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            mkd_pkg::REG_POLL_INTERVAL: cfg_in.poll_interval = csr_wdata[15:0];
            mkd_pkg::REG_SETTLE_TIME:   cfg_in.settle_time   = csr_wdata[15:0];
            mkd_pkg::REG_KEY_BIT_MAP:   cfg_in.key_bit_map   = csr_wdata[20:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   assign last_poll_in = sample ? now_ms : last_poll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poll_interval <= mkd_pkg::POLL_RESET;
         cfg_ff.settle_time   <= mkd_pkg::SETTLE_RESET;
         cfg_ff.key_bit_map   <= mkd_pkg::MAP_RESET;
         last_poll_ff         <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         last_poll_ff <= last_poll_in;
      end
   end

   for (genvar i = 0; i < KEY_COUNT; i++) begin : g_lane
      localparam int LOW = mkd_pkg::SEL_WIDTH * i;
      logic [mkd_pkg::SEL_WIDTH-1:0] sel;
      mkd_pkg::lane_status_type      status;

      if (LOW + mkd_pkg::SEL_WIDTH <= mkd_pkg::MAP_WIDTH) begin : g_map
         assign sel = cfg_ff.key_bit_map[LOW +: mkd_pkg::SEL_WIDTH];
      end else begin : g_nomap
         assign sel = '0;
      end

      mkd_key_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .sample      (sample),
         .raw         (~port_bits[sel]),
         .now_ms      (now_ms),
         .settle_time (cfg_ff.settle_time),
         .status      (status)
      );

      assign key_stable[i] = status.stable;
   end

   mkd_key_lane u_boot_lane (
      .clock       (clock),
      .reset       (reset),
      .sample      (sample),
      .raw         (~boot_level),
      .now_ms      (now_ms),
      .settle_time (cfg_ff.settle_time),
      .status      (boot_status)
   );

   mkd_merge #(
      .KEY_COUNT (KEY_COUNT)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat),
      .take       (take_boot_event),
      .key_stable (key_stable),
      .boot_press (boot_status.press),
      .result     (result)
   );

   mkd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (beat),
      .in_ready  (req_tready),
      .in_data   (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = rsp_data;

`ifndef NO_ASSERTIONS
   a_stall_needs_result: assert property (
      @(posedge clock) disable iff (reset) !req_tready |-> rsp_tvalid
   ) else $error("input stalled with no result waiting");

   a_poll_time_taken: assert property (
      @(posedge clock) disable iff (reset) sample |=> last_poll_ff == $past(now_ms)
   ) else $error("poll time not recorded");

   a_no_poll_holds: assert property (
      @(posedge clock) disable iff (reset) !sample |=> $stable(last_poll_ff)
   ) else $error("poll time moved without a poll");

   a_beat_gives_result: assert property (
      @(posedge clock) disable iff (reset) beat |=> rsp_tvalid
   ) else $error("beat accepted but no result offered");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_multi_key_debouncer.sv]
`timescale 1ns / 100ps

module tb_multi_key_debouncer;

   localparam int KEYS = 7;
   localparam int MAX_REPORTS = 10;
   localparam logic [mkd_pkg::CSR_IDX_WIDTH-1:0] REG_UNUSED = 2'd3;

   typedef logic [mkd_pkg::CSR_DATA_WIDTH-1:0] csr_word_type;
   typedef logic [mkd_pkg::PORT_WIDTH-1:0]     port_byte_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic [mkd_pkg::REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                               req_tvalid = 1'b0;
   wire                                req_tready;
   wire  [mkd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   wire                                rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic                               csr_wr_en = 1'b0;
   logic [mkd_pkg::CSR_IDX_WIDTH-1:0]  csr_index = '0;
   logic [mkd_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // debouncer model state
   logic [mkd_pkg::IVAL_WIDTH-1:0] poll_ival;
   logic [mkd_pkg::IVAL_WIDTH-1:0] settle_ms;
   logic [mkd_pkg::MAP_WIDTH-1:0]  key_map;
   logic [KEYS-1:0]                raw_keys;
   logic [KEYS-1:0]                stable_keys;
   logic [mkd_pkg::TIME_WIDTH-1:0] key_stamp [KEYS];
   logic                           boot_raw_q;
   logic                           boot_stable_q;
   logic                           boot_latched;
   logic [mkd_pkg::TIME_WIDTH-1:0] boot_stamp;
   logic [mkd_pkg::TIME_WIDTH-1:0] poll_stamp_ms;

   mkd_pkg::rsp_type expected_rsp [$];
   int      fail_count = 0;
   bit      calm = 1'b0;
   int      hold_cycles = 0;

   logic [mkd_pkg::TIME_WIDTH-1:0] stamp_ms;
   logic [mkd_pkg::PORT_WIDTH-1:0] held_port;
   logic                           held_boot;

   multi_key_debouncer #(
      .KEY_COUNT(KEYS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic bit idle_roll();
      return !calm && ($urandom_range(99) < 35);
   endfunction

   task automatic model_reset();
      poll_ival     = mkd_pkg::POLL_RESET;
      settle_ms     = mkd_pkg::SETTLE_RESET;
      key_map       = mkd_pkg::MAP_RESET;
      raw_keys      = '0;
      stable_keys   = '0;
      for (int i = 0; i < KEYS; i++) key_stamp[i] = '0;
      boot_raw_q    = 1'b0;
      boot_stable_q = 1'b0;
      boot_latched  = 1'b0;
      boot_stamp    = '0;
      poll_stamp_ms = '0;
   endtask

   task automatic predict_keys(input logic [mkd_pkg::TIME_WIDTH-1:0] now,
                               input logic [mkd_pkg::PORT_WIDTH-1:0] port,
                               input logic boot_level, input logic take,
                               output mkd_pkg::rsp_type result);
      logic [mkd_pkg::TIME_WIDTH-1:0] elapsed;
      logic [mkd_pkg::SEL_WIDTH-1:0]  sel;
      logic                           raw;
      logic                           boot_raw;
      boot_raw = ~boot_level;
      elapsed = now - poll_stamp_ms;
      if (elapsed >= {16'd0, poll_ival}) begin
         poll_stamp_ms = now;
         for (int i = 0; i < KEYS; i++) begin
            sel = key_map[3*i +: 3];
            raw = ~port[sel];
            elapsed = now - key_stamp[i];
            if (raw != raw_keys[i]) begin
               raw_keys[i] = raw;
               key_stamp[i] = now;
            end else if (raw != stable_keys[i] && elapsed >= {16'd0, settle_ms}) begin
               stable_keys[i] = raw;
            end
         end
         elapsed = now - boot_stamp;
         if (boot_raw != boot_raw_q) begin
            boot_raw_q = boot_raw;
            boot_stamp = now;
         end else if (boot_raw != boot_stable_q && elapsed >= {16'd0, settle_ms}) begin
            boot_stable_q = boot_raw;
            if (boot_raw) boot_latched = 1'b1;
         end
      end
      result.boot_event = 1'b0;
      if (take && boot_latched) begin
         boot_latched = 1'b0;
         result.boot_event = 1'b1;
      end
      result.pressed_mask = stable_keys;
   endtask

   task automatic send_sample(input logic [mkd_pkg::TIME_WIDTH-1:0] now,
                              input logic [mkd_pkg::PORT_WIDTH-1:0] port,
                              input logic boot_level, input logic take);
      mkd_pkg::rsp_type want;
      @(negedge clock);
      while (idle_roll()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {6'd0, take, boot_level, port, now};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_keys(now, port, boot_level, take, want);
      expected_rsp.push_back(want);
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [mkd_pkg::CSR_IDX_WIDTH-1:0] idx,
                            input logic [mkd_pkg::CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         mkd_pkg::REG_POLL_INTERVAL: poll_ival = value[mkd_pkg::IVAL_WIDTH-1:0];
         mkd_pkg::REG_SETTLE_TIME:   settle_ms = value[mkd_pkg::IVAL_WIDTH-1:0];
         mkd_pkg::REG_KEY_BIT_MAP:   key_map   = value[mkd_pkg::MAP_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic write_all_regs(input logic [mkd_pkg::CSR_DATA_WIDTH-1:0] poll,
                                 input logic [mkd_pkg::CSR_DATA_WIDTH-1:0] settle,
                                 input logic [mkd_pkg::CSR_DATA_WIDTH-1:0] map);
      write_reg(mkd_pkg::REG_POLL_INTERVAL, poll);
      write_reg(mkd_pkg::REG_SETTLE_TIME, settle);
      write_reg(mkd_pkg::REG_KEY_BIT_MAP, map);
   endtask

   // mostly held levels that settle, with bounce, level changes and time jumps
   task automatic send_random_samples(input int count, input int unsigned max_step);
      int unsigned                    dt;
      int                             b;
      logic [mkd_pkg::PORT_WIDTH-1:0] port;
      logic                           boot;
      repeat (count) begin
         case ($urandom_range(19))
            0:       dt = $urandom();
            1:       dt = 0;
            default: dt = $urandom_range(max_step);
         endcase
         stamp_ms = stamp_ms + dt;
         if ($urandom_range(9) == 0) begin
            if ($urandom_range(1) == 0) begin
               held_port = port_byte_type'($urandom());
            end else begin
               b = $urandom_range(mkd_pkg::PORT_WIDTH-1);
               held_port[b] = ~held_port[b];
            end
         end
         if ($urandom_range(11) == 0) held_boot = ~held_boot;
         port = held_port;
         boot = held_boot;
         if ($urandom_range(11) == 0) port = port_byte_type'($urandom());
         if ($urandom_range(15) == 0) boot = ~boot;
         send_sample(stamp_ms, port, boot, $urandom_range(3) == 0);
      end
   endtask

   always @(posedge clock) begin : rsp_checker
      mkd_pkg::rsp_type seen;
      mkd_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata;
         if (expected_rsp.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected result beat %h", rsp_tdata);
         end else begin
            want = expected_rsp.pop_front();
            if (seen.pressed_mask !== want.pressed_mask ||
                seen.boot_event !== want.boot_event) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("mismatch: pressed_mask exp %h got %h, boot_event exp %b got %b",
                           want.pressed_mask, seen.pressed_mask,
                           want.boot_event, seen.boot_event);
            end
         end
      end
   end

   initial begin : rsp_ready_driver
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles != 0) begin
            stall_left = hold_cycles;
            hold_cycles = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !idle_roll();
         end
      end
   end

   // reset values, poll not due, take in the same beat as the press, timer wrap
   task automatic test_directed_defaults();
      send_sample(32'd0,        8'hFF, 1'b1, 1'b1);
      send_sample(32'd20,       8'h00, 1'b0, 1'b0);
      send_sample(32'd30,       8'h00, 1'b0, 1'b1);
      send_sample(32'd40,       8'h00, 1'b0, 1'b0);
      send_sample(32'd55,       8'h00, 1'b0, 1'b1);
      send_sample(32'd56,       8'h00, 1'b0, 1'b1);
      send_sample(32'd80,       8'h55, 1'b0, 1'b0);
      send_sample(32'hFFFFFFF0, 8'h55, 1'b1, 1'b0);
      send_sample(32'h00000010, 8'h55, 1'b1, 1'b1);
      send_sample(32'h00000030, 8'hAA, 1'b0, 1'b0);
      send_sample(32'h00000050, 8'hAA, 1'b0, 1'b1);
      send_sample(32'h00000070, 8'hAA, 1'b0, 1'b1);
      send_sample(32'hFFFFFFFF, 8'hFF, 1'b1, 1'b1);
      wait_all_results();
   endtask

   // zero poll and settle: a raw change still holds the stable level for one poll
   task automatic test_zero_intervals();
      write_all_regs('0, '0, mkd_pkg::MAP_RESET);
      send_sample(32'd100, 8'h00, 1'b0, 1'b1);
      send_sample(32'd100, 8'h00, 1'b0, 1'b1);
      send_sample(32'd100, 8'hFF, 1'b1, 1'b0);
      send_sample(32'd100, 8'hFF, 1'b1, 1'b1);
      send_sample(32'd101, 8'h7F, 1'b0, 1'b0);
      send_sample(32'd101, 8'h7F, 1'b0, 1'b0);
      send_sample(32'd102, 8'h7F, 1'b0, 1'b1);
      wait_all_results();
   endtask

   // high bits dropped, unused index ignored, all keys on one port bit
   task automatic test_register_writes();
      stamp_ms = 32'h8000_0000;
      write_all_regs(21'h1F0008, 21'h1E0005, '0);
      write_reg(REG_UNUSED, csr_word_type'($urandom()));
      send_random_samples(12, 12);
      wait_all_results();
      write_all_regs(21'h0A0002, 21'h150003, 21'h1FFFFF);
      write_reg(REG_UNUSED, 21'h1FFFFF);
      send_random_samples(12, 6);
      wait_all_results();
   endtask

   task automatic test_random_settings();
      logic [mkd_pkg::CSR_DATA_WIDTH-1:0] poll;
      logic [mkd_pkg::CSR_DATA_WIDTH-1:0] settle;
      int unsigned                        max_step;
      stamp_ms = $urandom();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               poll     = csr_word_type'(mkd_pkg::POLL_RESET);
               settle   = csr_word_type'(mkd_pkg::SETTLE_RESET);
               max_step = 40;
            end
            1: begin poll = '0; settle = '0; max_step = 3; end
            2: begin poll = 21'h1FFFFF; settle = 21'h1FFFFF; max_step = 32'h14000; end
            3: begin poll = 21'd1; settle = 21'd5; max_step = 4; end
            4: begin poll = 21'd3; settle = 21'h00FFFF; max_step = 8; end
            default: begin
               poll = csr_word_type'({$urandom_range(31, 0), 16'h0000} |
                                     $urandom_range(10));
               settle = csr_word_type'($urandom_range(40));
               max_step = 24;
            end
         endcase
         write_all_regs(poll, settle,
                        (phase == 0) ? mkd_pkg::MAP_RESET : csr_word_type'($urandom()));
         send_random_samples(80, max_step);
         wait_all_results();
      end
   endtask

   // receiver holds off while beats keep coming, so the input stalls
   task automatic test_output_stall();
      write_all_regs(21'd2, 21'd6, csr_word_type'($urandom()));
      hold_cycles = 60;
      send_random_samples(40, 5);
      wait_all_results();
   endtask

   task automatic test_no_idle();
      write_all_regs(21'd1, 21'd3, csr_word_type'($urandom()));
      calm = 1'b1;
      send_random_samples(60, 3);
      wait_all_results();
      calm = 1'b0;
   endtask

   initial begin
      model_reset();
      stamp_ms  = '0;
      held_port = 8'hFF;
      held_boot = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_defaults();
      test_zero_intervals();
      test_register_writes();
      test_random_settings();
      test_output_stall();
      test_no_idle();
      wait_all_results();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[files.f]
sv/mkd_pkg.sv
sv/mkd_key_lane.sv
sv/mkd_merge.sv
sv/mkd_skid.sv
sv/multi_key_debouncer.sv
tb/sv/tb_multi_key_debouncer.sv
